FILE: design/aabb_xfm_pkg.sv
// package for the bounding box transform unit
// word types, register indexes and reset values; no dependencies
`default_nettype none

package aabb_xfm_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int HALF_WIDTH  = COORD_WIDTH - 1;
	localparam int COEF_WIDTH  = 16;
	localparam int ROW_WIDTH   = 3 * COEF_WIDTH;
	localparam int FRAC_SHIFT  = 12;

	localparam int NUM_REGS   = 6;
	localparam int ADDR_WIDTH = 6;
	localparam int DATA_WIDTH = 64;

	localparam logic [2:0] REG_ROW_X   = 3'd0;
	localparam logic [2:0] REG_ROW_Y   = 3'd1;
	localparam logic [2:0] REG_ROW_Z   = 3'd2;
	localparam logic [2:0] REG_SHIFT_X = 3'd3;
	localparam logic [2:0] REG_SHIFT_Y = 3'd4;
	localparam logic [2:0] REG_SHIFT_Z = 3'd5;

	localparam logic [ROW_WIDTH-1:0] ROW_X_RESET = 48'h0000_0000_1000;
	localparam logic [ROW_WIDTH-1:0] ROW_Y_RESET = 48'h0000_1000_0000;
	localparam logic [ROW_WIDTH-1:0] ROW_Z_RESET = 48'h1000_0000_0000;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] center_x;
		logic signed [COORD_WIDTH-1:0] center_y;
		logic signed [COORD_WIDTH-1:0] center_z;
		logic [HALF_WIDTH-1:0]         half_x;
		logic [HALF_WIDTH-1:0]         half_y;
		logic [HALF_WIDTH-1:0]         half_z;
	} box_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] new_center_x;
		logic signed [COORD_WIDTH-1:0] new_center_y;
		logic signed [COORD_WIDTH-1:0] new_center_z;
		logic [HALF_WIDTH-1:0]         new_half_x;
		logic [HALF_WIDTH-1:0]         new_half_y;
		logic [HALF_WIDTH-1:0]         new_half_z;
	} res_t;

endpackage

`default_nettype wire

FILE: design/aabb_transform_by_matrix_unit.sv
// affine transform of an axis-aligned bounding box, three-stage pipeline
// depends on aabb_xfm_pkg for word types, register map and reset values
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  box      | box_valid/box_ready  | box_data (centre, half-extents)
//  res      | res_valid/res_ready  | res_data (new centre, new halves)
//  apb      | psel/penable/pready  | paddr, pwrite, pwdata, prdata
//
// three register stages, res_valid rising from stage 3; while res_ready is high,
// one word per cycle is sustained and every stage takes a new word each cycle
// stage 1 multiplies, stage 2 sums and rounds, stage 3 adds shift and saturates
// each stage advances when it is empty or the next one advances, so a stall
// squeezes out bubbles and holds words in place
// arst_n clears the valid bits and loads the identity matrix and zero shift
`default_nettype none

module aabb_transform_by_matrix_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            box_valid,
	output logic                                 box_ready,
	input  wire aabb_xfm_pkg::box_t              box_data,
	output logic                                 res_valid,
	input  wire logic                            res_ready,
	output aabb_xfm_pkg::res_t                   res_data,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [aabb_xfm_pkg::ADDR_WIDTH-1:0] paddr,
	input  wire logic [aabb_xfm_pkg::DATA_WIDTH-1:0] pwdata,
	output logic [aabb_xfm_pkg::DATA_WIDTH-1:0]  prdata,
	output logic                                 pready
);
	import aabb_xfm_pkg::*;

	localparam int PROD_C_W = COORD_WIDTH + COEF_WIDTH;     // signed product
	localparam int PROD_H_W = HALF_WIDTH + COEF_WIDTH;      // unsigned product
	localparam int SUM_C_W  = PROD_C_W + 2;
	localparam int SUM_H_W  = PROD_H_W + 2;
	localparam int RND_C_W  = SUM_C_W - FRAC_SHIFT;
	localparam int RND_H_W  = SUM_H_W - FRAC_SHIFT;
	localparam int FIN_C_W  = RND_C_W + 1;

	localparam logic signed [FIN_C_W-1:0] C_MAX =
		(FIN_C_W'(1) <<< (COORD_WIDTH - 1)) - FIN_C_W'(1);
	localparam logic signed [FIN_C_W-1:0] C_MIN = -C_MAX - FIN_C_W'(1);
	localparam logic [RND_H_W-1:0] H_MAX = (RND_H_W'(1) << HALF_WIDTH) - RND_H_W'(1);
	localparam logic signed [SUM_C_W-1:0] RND_C = SUM_C_W'(1) <<< (FRAC_SHIFT - 1);
	localparam logic [SUM_H_W-1:0] RND_H = SUM_H_W'(1) << (FRAC_SHIFT - 1);

	// configuration registers
	logic [ROW_WIDTH-1:0]          row_q   [3];
	logic signed [COORD_WIDTH-1:0] shift_q [3];

	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[ADDR_WIDTH-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]   <= ROW_X_RESET;
			row_q[1]   <= ROW_Y_RESET;
			row_q[2]   <= ROW_Z_RESET;
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ROW_X:   row_q[0]   <= pwdata[ROW_WIDTH-1:0];
				REG_ROW_Y:   row_q[1]   <= pwdata[ROW_WIDTH-1:0];
				REG_ROW_Z:   row_q[2]   <= pwdata[ROW_WIDTH-1:0];
				REG_SHIFT_X: shift_q[0] <= pwdata[COORD_WIDTH-1:0];
				REG_SHIFT_Y: shift_q[1] <= pwdata[COORD_WIDTH-1:0];
				REG_SHIFT_Z: shift_q[2] <= pwdata[COORD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_ROW_X:   prdata = DATA_WIDTH'(row_q[0]);
			REG_ROW_Y:   prdata = DATA_WIDTH'(row_q[1]);
			REG_ROW_Z:   prdata = DATA_WIDTH'(row_q[2]);
			REG_SHIFT_X: prdata = DATA_WIDTH'($unsigned(shift_q[0]));
			REG_SHIFT_Y: prdata = DATA_WIDTH'($unsigned(shift_q[1]));
			REG_SHIFT_Z: prdata = DATA_WIDTH'($unsigned(shift_q[2]));
			default:     prdata = '0;
		endcase
	end

	// stage enables
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	assign en3       = !v_s3 || res_ready;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign box_ready = en1;
	assign res_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= box_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// stage 1: products
	logic signed [COORD_WIDTH-1:0] cin [3];
	logic [HALF_WIDTH-1:0]         hin [3];
	logic signed [PROD_C_W-1:0]    pc  [3][3];
	logic [PROD_H_W-1:0]           ph  [3][3];
	logic signed [PROD_C_W-1:0]    pc_s1 [3][3];
	logic [PROD_H_W-1:0]           ph_s1 [3][3];

	assign cin[0] = box_data.center_x;
	assign cin[1] = box_data.center_y;
	assign cin[2] = box_data.center_z;
	assign hin[0] = box_data.half_x;
	assign hin[1] = box_data.half_y;
	assign hin[2] = box_data.half_z;

	always_comb begin
		logic signed [COEF_WIDTH-1:0] a;
		logic [COEF_WIDTH-1:0]        mag;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				a        = $signed(row_q[r][COEF_WIDTH*k +: COEF_WIDTH]);
				// the most negative code maps to its unsigned magnitude
				mag      = a[COEF_WIDTH-1] ? $unsigned(-a) : $unsigned(a);
				pc[r][k] = PROD_C_W'(cin[k]) * PROD_C_W'(a);
				ph[r][k] = PROD_H_W'(hin[k]) * PROD_H_W'(mag);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && box_valid) begin
			pc_s1 <= pc;
			ph_s1 <= ph;
		end
	end

	// stage 2: exact sums, round half up to Q16.16
	logic signed [RND_C_W-1:0] rc [3];
	logic [RND_H_W-1:0]        rh [3];
	logic signed [RND_C_W-1:0] rc_s2 [3];
	logic [RND_H_W-1:0]        rh_s2 [3];

	always_comb begin
		logic signed [SUM_C_W-1:0] sc;
		logic [SUM_H_W-1:0]        sh;
		for (int r = 0; r < 3; r++) begin
			sc = SUM_C_W'(pc_s1[r][0]) + SUM_C_W'(pc_s1[r][1])
			   + SUM_C_W'(pc_s1[r][2]) + RND_C;
			sh = SUM_H_W'(ph_s1[r][0]) + SUM_H_W'(ph_s1[r][1])
			   + SUM_H_W'(ph_s1[r][2]) + RND_H;
			// floor division by 4096 is an arithmetic shift
			rc[r] = sc[SUM_C_W-1:FRAC_SHIFT];
			rh[r] = sh[SUM_H_W-1:FRAC_SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			rc_s2 <= rc;
			rh_s2 <= rh;
		end
	end

	// stage 3: translation and saturation, output register
	logic signed [COORD_WIDTH-1:0] fc [3];
	logic [HALF_WIDTH-1:0]         fh [3];

	always_comb begin
		logic signed [FIN_C_W-1:0] t;
		for (int r = 0; r < 3; r++) begin
			t = FIN_C_W'(rc_s2[r]) + FIN_C_W'(shift_q[r]);
			priority if (t > C_MAX) fc[r] = C_MAX[COORD_WIDTH-1:0];
			else if (t < C_MIN)     fc[r] = C_MIN[COORD_WIDTH-1:0];
			else                    fc[r] = t[COORD_WIDTH-1:0];
			fh[r] = (rh_s2[r] > H_MAX) ? H_MAX[HALF_WIDTH-1:0] : rh_s2[r][HALF_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			res_data.new_center_x <= fc[0];
			res_data.new_center_y <= fc[1];
			res_data.new_center_z <= fc[2];
			res_data.new_half_x   <= fh[0];
			res_data.new_half_y   <= fh[1];
			res_data.new_half_z   <= fh[2];
		end
	end

endmodule

`default_nettype wire
